/* hw/rtl/ipimb_pkg.sv */
// Shared types, codes and access decode for the IPI mailbox register block.
package ipimb_pkg;

  localparam logic [7:0] OFF_STATUS  = 8'h00;
  localparam logic [7:0] OFF_ENABLE  = 8'h04;
  localparam logic [7:0] OFF_SET     = 8'h08;
  localparam logic [7:0] OFF_CLEAR   = 8'h0C;
  localparam logic [7:0] OFF_MBOX_LO = 8'h20;
  localparam logic [7:0] OFF_MBOX_HI = 8'h38;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_RAISE = 2'd1;
  localparam logic [1:0] ACT_LOWER = 2'd2;

  localparam logic [1:0] BAD_OK      = 2'd0;
  localparam logic [1:0] BAD_ALIGN   = 2'd1;
  localparam logic [1:0] BAD_UNKNOWN = 2'd2;

  localparam int CORES_PER_NODE = 4;
  localparam int MBOX_ENTRIES   = 4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_STATUS,
    OP_ENABLE,
    OP_SET,
    OP_CLEAR,
    OP_MBOX
  } op_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  node;
    logic [1:0]  core;
    logic [7:0]  offset;
    logic        size_is_8;
    logic [63:0] write_data;
  } req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [1:0]  irq_action;
    logic [3:0]  irq_core;
    logic [1:0]  bad_access;
  } res_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] bad;
  } dec_t;

  // Classify one access: alignment first, then node range, then offset.
  function automatic dec_t ipimb_decode(logic [7:0] offset, logic size_is_8,
                                        logic node_ok);
    dec_t d;
    logic misaligned;
    misaligned = size_is_8 ? (offset[2:0] != 3'd0) : (offset[1:0] != 2'd0);
    d.op  = OP_NONE;
    d.bad = BAD_OK;
    if (misaligned) begin
      d.bad = BAD_ALIGN;
    end else if (!node_ok) begin
      d.bad = BAD_UNKNOWN;
    end else begin
      case (offset)
        OFF_STATUS: d.op = OP_STATUS;
        OFF_ENABLE: d.op = OP_ENABLE;
        OFF_SET:    d.op = OP_SET;
        OFF_CLEAR:  d.op = OP_CLEAR;
        default: begin
          if (offset inside {[OFF_MBOX_LO:OFF_MBOX_HI]}) d.op = OP_MBOX;
          else d.bad = BAD_UNKNOWN;
        end
      endcase
    end
    return d;
  endfunction

endpackage

/* hw/rtl/ipimb_if.sv */
// Valid/ready channel interfaces for bus accesses and their results.
interface ipimb_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  node;
  logic [1:0]  core;
  logic [7:0]  offset;
  logic        size_is_8;
  logic [63:0] write_data;

  modport source (output valid, kind, node, core, offset, size_is_8, write_data,
                  input ready);
  modport sink   (input valid, kind, node, core, offset, size_is_8, write_data,
                  output ready);
endinterface

interface ipimb_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] read_data;
  logic [1:0]  irq_action;
  logic [3:0]  irq_core;
  logic [1:0]  bad_access;

  modport source (output valid, read_data, irq_action, irq_core, bad_access,
                  input ready);
  modport sink   (input valid, read_data, irq_action, irq_core, bad_access,
                  output ready);
endinterface

/* hw/rtl/ipimb_mbox.sv */
// Mailbox storage: two 32-bit halves per entry, registered read, valid bits.
module ipimb_mbox #(
  parameter int ENTRIES = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic                       wr_lo,
  input  logic                       wr_hi,
  input  logic [$clog2(ENTRIES)-1:0] addr,
  input  logic [31:0]                wdata_lo,
  input  logic [31:0]                wdata_hi,
  output logic [63:0]                rdata
);

  logic [31:0]        mem_lo [ENTRIES];
  logic [31:0]        mem_hi [ENTRIES];
  logic [ENTRIES-1:0] vld_lo;
  logic [ENTRIES-1:0] vld_hi;
  logic [31:0]        rd_lo;
  logic [31:0]        rd_hi;
  logic               rd_lo_vld;
  logic               rd_hi_vld;

  // Write each half on its own so a 4-byte write needs no read-modify-write.
  always_ff @(posedge clk) begin
    if (wr_lo) mem_lo[addr] <= wdata_lo;
    if (wr_hi) mem_hi[addr] <= wdata_hi;
    if (rd_en) begin
      rd_lo <= mem_lo[addr];
      rd_hi <= mem_hi[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_lo    <= '0;
      vld_hi    <= '0;
      rd_lo_vld <= 1'b0;
      rd_hi_vld <= 1'b0;
    end else begin
      if (wr_lo) vld_lo[addr] <= 1'b1;
      if (wr_hi) vld_hi[addr] <= 1'b1;
      if (rd_en) begin
        rd_lo_vld <= vld_lo[addr];
        rd_hi_vld <= vld_hi[addr];
      end
    end
  end

  // An entry half never written reads as zero.
  assign rdata = {rd_hi_vld ? rd_hi : 32'd0, rd_lo_vld ? rd_lo : 32'd0};

endmodule

/* hw/rtl/ipimb_regs.sv */
// Per-core status and enable words, and the result of one access.
module ipimb_regs #(
  parameter int SLOTS = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  ipimb_pkg::req_t item,
  input  ipimb_pkg::dec_t dec,
  input  logic [63:0]     mbox_rdata,
  output ipimb_pkg::res_t res
);
  import ipimb_pkg::*;

  localparam int SLOT_W = $clog2(SLOTS);

  logic [31:0]       status [SLOTS];
  logic [31:0]       enable [SLOTS];
  logic [3:0]        full_id;
  logic [SLOT_W-1:0] slot;
  logic [31:0]       wd32;
  logic [31:0]       cur_status;
  logic [31:0]       cur_enable;
  logic [31:0]       cleared;
  logic              is_wr;
  logic              ok;

  assign full_id    = {item.node, item.core};
  assign slot       = full_id[SLOT_W-1:0];
  assign wd32       = item.write_data[31:0];
  assign is_wr      = item.kind;
  assign ok         = (dec.bad == BAD_OK);
  assign cur_status = ok ? status[slot] : 32'd0;
  assign cur_enable = ok ? enable[slot] : 32'd0;
  assign cleared    = cur_status & ~wd32;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        status[i] <= '0;
        enable[i] <= '0;
      end
    end else if (adv && is_wr && ok) begin
      case (dec.op)
        OP_ENABLE: enable[slot] <= wd32;
        OP_SET:    status[slot] <= cur_status | wd32;
        OP_CLEAR:  status[slot] <= cleared;
        default: ;
      endcase
    end
  end

  always_comb begin
    res.read_data  = 64'd0;
    res.irq_action = ACT_NONE;
    res.bad_access = dec.bad;
    case (dec.op)
      OP_STATUS: if (!is_wr) res.read_data = {32'd0, cur_status};
      OP_ENABLE: if (!is_wr) res.read_data = {32'd0, cur_enable};
      OP_SET:    if (is_wr) res.irq_action = ACT_RAISE;
      OP_CLEAR:  if (is_wr && cleared == 32'd0) res.irq_action = ACT_LOWER;
      OP_MBOX: begin
        if (!is_wr) begin
          if (item.size_is_8)      res.read_data = mbox_rdata;
          else if (item.offset[2]) res.read_data = {32'd0, mbox_rdata[63:32]};
          else                     res.read_data = {32'd0, mbox_rdata[31:0]};
        end
      end
      default: ;
    endcase
    res.irq_core = (res.irq_action == ACT_NONE) ? 4'd0 : full_id;
  end

endmodule

/* hw/rtl/ipi_mailbox_registers_top.sv */
// Top level of the inter-processor interrupt mailbox register block.
//
//   channel | dir | payload                                        | handshake
//   --------+-----+------------------------------------------------+----------
//   req     | in  | kind, node, core, offset, size_is_8, write_data | valid/ready
//   rsp     | out | read_data, irq_action, irq_core, bad_access     | valid/ready
//
// One item per cycle sustained while results are taken. An item waits in the
// input stage (mailbox read issued at accept), and its result is then
// registered in the result stage, where it stays offered until taken.
// Reset clears status, enable and the mailbox valid bits.
// A stalled result holds; the input stage still takes an item while empty.
module ipi_mailbox_registers_top #(
  parameter int NODES = 4
) (
  input logic        clk,
  input logic        rst,
  ipimb_req_if.sink   req,
  ipimb_rsp_if.source rsp
);
  import ipimb_pkg::*;

  localparam int SLOTS      = NODES * CORES_PER_NODE;
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int MB_ENTRIES = SLOTS * MBOX_ENTRIES;
  localparam int MB_W       = $clog2(MB_ENTRIES);

  // Decode of the item on the port, used at accept for the mailbox.
  logic              acc;
  logic              node_ok;
  dec_t              in_dec;
  logic [3:0]        in_id;
  logic              mb_wr;
  logic              wide;
  logic [MB_W-1:0]   mb_addr;

  // Input stage.
  logic              s1_valid;
  req_t              s1_req;
  dec_t              s1_dec;
  logic              s1_adv;

  // Result stage.
  logic              out_valid;
  res_t              res;
  res_t              res_next;
  logic [63:0]       mb_rdata;

  assign acc     = req.valid && req.ready;
  assign node_ok = (int'(req.node) < NODES);
  assign in_dec  = ipimb_decode(req.offset, req.size_is_8, node_ok);
  assign in_id   = {req.node, req.core};
  assign wide    = req.size_is_8;
  assign mb_wr   = acc && req.kind && (in_dec.op == OP_MBOX);
  // Entry within the core's mailbox comes from offset bits 4..3.
  assign mb_addr = {in_id[SLOT_W-1:0], req.offset[4:3]};

  // Advance the input stage when the result register is free or draining.
  assign s1_adv    = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_adv;

  ipimb_mbox #(
    .ENTRIES(MB_ENTRIES)
  ) u_mbox (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (acc && !req.kind && (in_dec.op == OP_MBOX)),
    .wr_lo    (mb_wr && (wide || !req.offset[2])),
    .wr_hi    (mb_wr && (wide || req.offset[2])),
    .addr     (mb_addr),
    .wdata_lo (req.write_data[31:0]),
    .wdata_hi (wide ? req.write_data[63:32] : req.write_data[31:0]),
    .rdata    (mb_rdata)
  );

  ipimb_regs #(
    .SLOTS(SLOTS)
  ) u_regs (
    .clk        (clk),
    .rst        (rst),
    .adv        (s1_adv),
    .item       (s1_req),
    .dec        (s1_dec),
    .mbox_rdata (mb_rdata),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc)         s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (s1_adv)         out_valid <= 1'b1;
      else if (rsp.ready) out_valid <= 1'b0;
    end
  end

  // Payload: capture at accept, hold while stalled.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_req.kind       <= req.kind;
      s1_req.node       <= req.node;
      s1_req.core       <= req.core;
      s1_req.offset     <= req.offset;
      s1_req.size_is_8  <= req.size_is_8;
      s1_req.write_data <= req.write_data;
      s1_dec            <= in_dec;
    end
    if (s1_adv) res <= res_next;
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = res.read_data;
  assign rsp.irq_action = res.irq_action;
  assign rsp.irq_core   = res.irq_core;
  assign rsp.bad_access = res.bad_access;

endmodule

/* hw/rtl/ipimb_check.sv */
// Port-level assertions for the IPI mailbox register block, with bind.
module ipimb_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] read_data,
  input logic [1:0]  irq_action,
  input logic [3:0]  irq_core,
  input logic [1:0]  bad_access
);
  import ipimb_pkg::*;

  // A result that is not taken stays offered.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A flagged access has no read data and no interrupt action.
  a_bad_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_access != BAD_OK |-> read_data == 64'd0 && irq_action == ACT_NONE)
    else $error("flagged access had an effect");

  // Without an action the core field reads zero.
  a_core_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_action == ACT_NONE |-> irq_core == 4'd0)
    else $error("irq_core set without action");

  // An interrupt action never comes with read data.
  a_act_no_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && irq_action != ACT_NONE |-> read_data == 64'd0)
    else $error("read data on a write with action");

endmodule

bind ipi_mailbox_registers_top ipimb_check u_ipimb_check (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (rsp.valid),
  .out_ready  (rsp.ready),
  .read_data  (rsp.read_data),
  .irq_action (rsp.irq_action),
  .irq_core   (rsp.irq_core),
  .bad_access (rsp.bad_access)
);
